[src/lbcd_pkg.sv]
// Shared types and constants for the LRU block cache directory.
// No dependencies; imported by every module of the directory.
package lbcd_pkg;

   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int LIMIT_W     = 5;
   localparam int COUNT_OUT_W = 5;
   localparam int ID_IN_W     = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_LOCK  = 2'd2,
      MODE_DROP  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_FULL         = 2'd1,
      STATUS_NOT_RESIDENT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_FIND_LRU,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic accept;
      logic lookup_step;
      logic apply;
      logic lru_step;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_stat_type;

endpackage

[src/lbcd_ctrl.sv]
// Sequencer for the LRU block cache directory: lookup scan, update, LRU scan, respond.
// Depends on lbcd_pkg for the state type and the command/status structs.
module lbcd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output lbcd_pkg::dp_cmd_type cmd,
   input  lbcd_pkg::dp_stat_type stat
);
   import lbcd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (stat.scan_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_FIND_LRU;
         end
         ST_FIND_LRU: begin
            if (stat.scan_done) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = start ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = start;
         end
         ST_LOOKUP: begin
            busy            = 1'b1;
            cmd.lookup_step = 1'b1;
         end
         ST_UPDATE: begin
            busy      = 1'b1;
            cmd.apply = 1'b1;
         end
         ST_FIND_LRU: begin
            busy         = 1'b1;
            cmd.lru_step = 1'b1;
         end
         ST_RESPOND: begin
            // result is on the ports this cycle; a new request may enter alongside it
            rsp_valid  = 1'b1;
            cmd.accept = start;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[src/lbcd_datapath.sv]
// Datapath of the LRU block cache directory: tag memory, per-entry valid/dirty/age,
// scan counter, lookup and LRU capture, update logic and result registers. Uses lbcd_pkg.
module lbcd_datapath #(
   parameter int ENTRIES = 16,
   parameter int ID_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lbcd_pkg::dp_cmd_type                cmd,
   output lbcd_pkg::dp_stat_type               stat,
   input  logic [lbcd_pkg::MODE_W-1:0]         req_mode,
   input  logic [lbcd_pkg::ID_IN_W-1:0]        req_block_id,
   input  logic                                csr_write,
   input  logic [lbcd_pkg::LIMIT_W-1:0]        csr_data,
   output logic [lbcd_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_hit,
   output logic                                rsp_fetch_needed,
   output logic                                rsp_writeback_needed,
   output logic [lbcd_pkg::COUNT_OUT_W-1:0]    rsp_resident_count,
   output logic                                rsp_lru_valid,
   output logic [lbcd_pkg::ID_IN_W-1:0]        rsp_lru_block
);
   import lbcd_pkg::*;

   localparam int AW    = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int WIDE  = (ID_BITS > ID_IN_W) ? ID_BITS : ID_IN_W;

   // request and configuration
   mode_type               mode_ff;
   logic [ID_BITS-1:0]     id_ff;
   logic [LIMIT_W-1:0]     limit_ff;
   logic [WIDE-1:0]        id_wide;

   // scan pipeline over the tag memory
   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic                   pipe_vld_ff;
   logic [AW-1:0]          pipe_idx_ff;
   logic [ID_BITS-1:0]     rd_tag_ff;
   logic [ID_BITS-1:0]     tag_mem [ENTRIES];
   logic                   issue;
   logic                   mem_we;

   // lookup results
   logic                   found_ff, found_in;
   logic [AW-1:0]          k_ff;
   logic [AW-1:0]          k_age_ff;
   logic                   k_dirty_ff;
   logic                   free_ff, free_in;
   logic [AW-1:0]          f_ff;
   logic                   match_hit, free_hit;

   // entry state
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [ENTRIES-1:0]     dirty_ff, dirty_in;
   logic [AW-1:0]          age_ff [ENTRIES];
   logic [AW-1:0]          age_in [ENTRIES];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   full;

   // result registers
   status_type             status_ff, status_in;
   logic                   hit_ff, hit_in;
   logic                   fetch_ff, fetch_in;
   logic                   wb_ff, wb_in;
   logic                   lru_ok_ff, lru_ok_in;
   logic [ID_BITS-1:0]     lru_tag_ff;
   logic                   lru_hit;
   logic [CMP_W-1:0]       count_wide;
   logic [WIDE-1:0]        lru_wide;

   assign id_wide = WIDE'(req_block_id);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= mode_type'(req_mode);
         id_ff   <= id_wide[ID_BITS-1:0];
      end
   end

   // ---------------- scan counter and tag memory ----------------
   assign issue          = (cmd.lookup_step | cmd.lru_step) && (scan_cnt_ff != CNT_W'(ENTRIES));
   assign stat.scan_done = (scan_cnt_ff == CNT_W'(ENTRIES));

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      priority if (cmd.accept || cmd.apply) begin
         scan_cnt_in = '0;
      end else if (issue) begin
         scan_cnt_in = scan_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         scan_cnt_ff <= scan_cnt_in;
         pipe_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         pipe_idx_ff <= scan_cnt_ff[AW-1:0];
      end
   end

   assign mem_we = cmd.apply && (mode_ff != MODE_DROP) && !found_ff && !full;

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_tag_ff <= tag_mem[scan_cnt_ff[AW-1:0]];
      end
      if (mem_we) begin
         tag_mem[f_ff] <= id_ff;
      end
   end

   // ---------------- lookup capture ----------------
   assign match_hit = cmd.lookup_step && pipe_vld_ff && valid_ff[pipe_idx_ff]
                      && (rd_tag_ff == id_ff) && !found_ff;
   assign free_hit  = cmd.lookup_step && pipe_vld_ff && !valid_ff[pipe_idx_ff] && !free_ff;

   always_comb begin
      found_in = found_ff;
      free_in  = free_ff;
      if (cmd.accept) begin
         found_in = 1'b0;
         free_in  = 1'b0;
      end else begin
         if (match_hit) found_in = 1'b1;
         if (free_hit)  free_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         found_ff <= found_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (match_hit) begin
         k_ff       <= pipe_idx_ff;
         k_age_ff   <= age_ff[pipe_idx_ff];
         k_dirty_ff <= dirty_ff[pipe_idx_ff];
      end
      if (free_hit) begin
         f_ff <= pipe_idx_ff;
      end
   end

   // a missing entry also needs a free slot; a limit above the entry count never binds
   assign full = (CMP_W'(count_ff) >= CMP_W'(limit_ff)) || !free_ff;

   // ---------------- entry update ----------------
   always_comb begin
      valid_in  = valid_ff;
      dirty_in  = dirty_ff;
      age_in    = age_ff;
      count_in  = count_ff;
      status_in = status_ff;
      hit_in    = hit_ff;
      fetch_in  = fetch_ff;
      wb_in     = wb_ff;
      if (cmd.apply) begin
         status_in = STATUS_OK;
         hit_in    = 1'b0;
         fetch_in  = 1'b0;
         wb_in     = 1'b0;
         priority if (mode_ff == MODE_DROP) begin
            if (found_ff) begin
               hit_in = 1'b1;
               wb_in  = k_dirty_ff;
               // close the gap: entries older than the dropped one move up
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i] && (k_ff != AW'(i)) && (age_ff[i] > k_age_ff)) begin
                     age_in[i] = age_ff[i] - AW'(1);
                  end
               end
               valid_in[k_ff] = 1'b0;
               dirty_in[k_ff] = 1'b0;
               age_in[k_ff]   = '0;
               count_in       = count_ff - CNT_W'(1);
            end else begin
               status_in = STATUS_NOT_RESIDENT;
            end
         end else if (found_ff) begin
            hit_in = 1'b1;
            if (mode_ff != MODE_LOCK) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i] && (k_ff != AW'(i)) && (age_ff[i] < k_age_ff)) begin
                     age_in[i] = age_ff[i] + AW'(1);
                  end
               end
               age_in[k_ff] = '0;
            end
            if (mode_ff == MODE_WRITE) begin
               dirty_in[k_ff] = 1'b1;
            end
         end else if (full) begin
            status_in = STATUS_FULL;
         end else begin
            fetch_in = 1'b1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i]) begin
                  age_in[i] = age_ff[i] + AW'(1);
               end
            end
            valid_in[f_ff] = 1'b1;
            dirty_in[f_ff] = (mode_ff == MODE_WRITE);
            age_in[f_ff]   = '0;
            count_in       = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         count_ff <= count_in;
         age_ff   <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      hit_ff    <= hit_in;
      fetch_ff  <= fetch_in;
      wb_ff     <= wb_in;
   end

   // ---------------- LRU search: the oldest entry has age count-1 ----------------
   assign lru_hit = cmd.lru_step && pipe_vld_ff && valid_ff[pipe_idx_ff]
                    && ((CNT_W'(age_ff[pipe_idx_ff]) + CNT_W'(1)) == count_ff);

   always_comb begin
      lru_ok_in = lru_ok_ff;
      priority if (cmd.apply) begin
         lru_ok_in = 1'b0;
      end else if (lru_hit) begin
         lru_ok_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lru_ok_ff <= 1'b0;
      end else begin
         lru_ok_ff <= lru_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.apply) begin
         lru_tag_ff <= '0;
      end else if (lru_hit) begin
         lru_tag_ff <= rd_tag_ff;
      end
   end

   assign count_wide           = CMP_W'(count_ff);
   assign lru_wide             = WIDE'(lru_tag_ff);
   assign rsp_status           = status_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_fetch_needed     = fetch_ff;
   assign rsp_writeback_needed = wb_ff;
   assign rsp_resident_count   = count_wide[COUNT_OUT_W-1:0];
   assign rsp_lru_valid        = lru_ok_ff;
   assign rsp_lru_block        = lru_wide[ID_IN_W-1:0];

endmodule

[src/lru_block_cache_directory.sv]
// Fully associative LRU block cache directory. The result strobe follows the lookup scan, the
// update, the LRU scan and the result state, in that order; one request is handled at a time.
// Requests are paced by the single read port of the tag memory, which is swept once for the
// lookup and once for the LRU entry; a new request may be started in the cycle the result is
// shown. The receiver cannot stall.
// Reset (synchronous, active high) empties the directory and sets the entry limit to 16.
module lru_block_cache_directory #(
   parameter int ENTRIES = 16,
   parameter int ID_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [lbcd_pkg::MODE_W-1:0]        req_mode,
   input  logic [lbcd_pkg::ID_IN_W-1:0]       req_block_id,
   output logic                               rsp_valid,
   output logic [lbcd_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_hit,
   output logic                               rsp_fetch_needed,
   output logic                               rsp_writeback_needed,
   output logic [lbcd_pkg::COUNT_OUT_W-1:0]   rsp_resident_count,
   output logic                               rsp_lru_valid,
   output logic [lbcd_pkg::ID_IN_W-1:0]       rsp_lru_block,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lbcd_pkg::LIMIT_W-1:0]       csr_data
);
   import lbcd_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = ~busy;

   lbcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   lbcd_datapath #(
      .ENTRIES (ENTRIES),
      .ID_BITS (ID_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_mode             (req_mode),
      .req_block_id         (req_block_id),
      .csr_write            (csr_valid & csr_ready),
      .csr_data             (csr_data),
      .rsp_status           (rsp_status),
      .rsp_hit              (rsp_hit),
      .rsp_fetch_needed     (rsp_fetch_needed),
      .rsp_writeback_needed (rsp_writeback_needed),
      .rsp_resident_count   (rsp_resident_count),
      .rsp_lru_valid        (rsp_lru_valid),
      .rsp_lru_block        (rsp_lru_block)
   );

endmodule

[src/lbcd_checker.sv]
// Port-level checks for the LRU block cache directory, bound to the top level.
// Depends on lbcd_pkg for the status codes.
module lbcd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [lbcd_pkg::STATUS_W-1:0]      rsp_status,
   input logic                               rsp_hit,
   input logic                               rsp_fetch_needed,
   input logic                               rsp_writeback_needed,
   input logic [lbcd_pkg::COUNT_OUT_W-1:0]   rsp_resident_count,
   input logic                               rsp_lru_valid
);
   import lbcd_pkg::*;

   // a request transfer always leads to a busy period
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer not followed by busy");

   // one strobe per request, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // refused requests change nothing and report no hit, fetch or writeback
   a_refused_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_NOT_RESIDENT))
      |-> (!rsp_hit && !rsp_fetch_needed && !rsp_writeback_needed))
      else $error("refused request reported hit, fetch or writeback");

   // a fetch means a miss that was allocated, so the directory is not empty afterwards
   a_fetch_alloc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fetch_needed)
      |-> (!rsp_hit && rsp_lru_valid && rsp_status == STATUS_OK))
      else $error("fetch reported without a fresh allocation");

   // no LRU entry only when nothing is resident
   a_empty_lru: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_lru_valid) |-> (rsp_resident_count == '0 && !rsp_fetch_needed))
      else $error("LRU entry missing while entries are resident");

endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_status           (rsp_status),
   .rsp_hit              (rsp_hit),
   .rsp_fetch_needed     (rsp_fetch_needed),
   .rsp_writeback_needed (rsp_writeback_needed),
   .rsp_resident_count   (rsp_resident_count),
   .rsp_lru_valid        (rsp_lru_valid)
);

[tb/tb_lru_block_cache_directory.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lru_block_cache_directory: a stimulus table, then random phases.
// Depends on lbcd_pkg and the directory RTL; expected results come from an in-bench predictor or typed rows.
module tb_lru_block_cache_directory;
   import lbcd_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int ID_BITS     = 32;
   localparam int LATENCY     = 2 * ENTRIES + 4;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASES      = 11;
   localparam int PHASE_ITEMS = 150;
   localparam int MAX_POOL    = 24;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic                   hit;
      logic                   fetch_needed;
      logic                   writeback_needed;
      logic [COUNT_OUT_W-1:0] resident_count;
      logic                   lru_valid;
      logic [ID_IN_W-1:0]     lru_block;
   } dir_result_t;

   typedef struct packed {
      logic                is_cfg;
      logic [LIMIT_W-1:0]  limit;
      logic [MODE_W-1:0]   mode;
      logic [ID_IN_W-1:0]  block_id;
      logic                typed;
      dir_result_t         res;
   } stim_row_t;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [MODE_W-1:0]      req_mode;
   logic [ID_IN_W-1:0]     req_block_id;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   rsp_hit;
   logic                   rsp_fetch_needed;
   logic                   rsp_writeback_needed;
   logic [COUNT_OUT_W-1:0] rsp_resident_count;
   logic                   rsp_lru_valid;
   logic [ID_IN_W-1:0]     rsp_lru_block;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [LIMIT_W-1:0]     csr_data;

   // travel with each request so the monitor sees them at the accepting edge
   logic                   req_typed;
   dir_result_t            req_typed_res;

   // predictor copy of the directory
   logic [ID_IN_W-1:0]     dir_tag   [ENTRIES];
   logic                   dir_valid [ENTRIES];
   logic                   dir_dirty [ENTRIES];
   int                     dir_age   [ENTRIES];
   int                     dir_used;
   int                     dir_limit;

   dir_result_t            expected_q [$];
   int                     pending_n;
   int                     mismatch_n;
   int                     items_n, retired_n, cfg_n;
   int                     hit_n, fetch_n, full_n, absent_n, wb_n;
   int                     burst_left;

   stim_row_t              directed_q [$];
   logic [ID_IN_W-1:0]     id_pool [MAX_POOL];
   int                     limit_plan [PHASES] = '{16, 1, 2, 31, 0, 8, 17, 4, 15, 3, 16};

   lru_block_cache_directory #(
      .ENTRIES (ENTRIES),
      .ID_BITS (ID_BITS)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_block_id         (req_block_id),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_hit              (rsp_hit),
      .rsp_fetch_needed     (rsp_fetch_needed),
      .rsp_writeback_needed (rsp_writeback_needed),
      .rsp_resident_count   (rsp_resident_count),
      .rsp_lru_valid        (rsp_lru_valid),
      .rsp_lru_block        (rsp_lru_block),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one access to the predicted directory and return the result it gives.
   function automatic dir_result_t apply_access(logic [MODE_W-1:0] mode,
                                                logic [ID_IN_W-1:0] id);
      dir_result_t r;
      int i, k, f, lim, best, aged;
      logic found;
      r = '0;
      k = -1;
      f = -1;
      lim = (dir_limit > ENTRIES) ? ENTRIES : dir_limit;
      for (i = 0; i < ENTRIES; i++) begin
         if (k < 0 && dir_valid[i] && dir_tag[i] == id) k = i;
         if (f < 0 && !dir_valid[i]) f = i;
      end
      if (mode == MODE_DROP) begin
         if (k < 0) begin
            r.status = STATUS_NOT_RESIDENT;
         end else begin
            r.hit = 1'b1;
            r.writeback_needed = dir_dirty[k];
            // close the gap left in the age order
            for (i = 0; i < ENTRIES; i++)
               if (dir_valid[i] && i != k && dir_age[i] > dir_age[k]) dir_age[i]--;
            dir_valid[k] = 1'b0;
            dir_dirty[k] = 1'b0;
            dir_age[k] = 0;
            if (dir_used > 0) dir_used--;
         end
      end else if (k >= 0) begin
         r.hit = 1'b1;
         if (mode != MODE_LOCK) begin
            aged = dir_age[k];
            for (i = 0; i < ENTRIES; i++)
               if (dir_valid[i] && i != k && dir_age[i] < aged) dir_age[i]++;
            dir_age[k] = 0;
         end
         if (mode == MODE_WRITE) dir_dirty[k] = 1'b1;
      end else if (dir_used >= lim || f < 0) begin
         r.status = STATUS_FULL;
      end else begin
         for (i = 0; i < ENTRIES; i++)
            if (dir_valid[i]) dir_age[i]++;
         dir_tag[f] = id;
         dir_valid[f] = 1'b1;
         dir_dirty[f] = (mode == MODE_WRITE);
         dir_age[f] = 0;
         dir_used++;
         r.fetch_needed = 1'b1;
      end
      found = 1'b0;
      best = 0;
      for (i = 0; i < ENTRIES; i++) begin
         if (dir_valid[i] && (!found || dir_age[i] > best)) begin
            found = 1'b1;
            best = dir_age[i];
            r.lru_block = dir_tag[i];
         end
      end
      r.resident_count = dir_used[COUNT_OUT_W-1:0];
      r.lru_valid = found;
      return r;
   endfunction

   task automatic log_mismatch(string what, logic [ID_IN_W-1:0] got, logic [ID_IN_W-1:0] want);
      mismatch_n++;
      $display("MISMATCH at result %0d, %s: got %0h, want %0h", retired_n, what, got, want);
   endtask

   task automatic compare_result(dir_result_t got, dir_result_t want);
      if (got.status !== want.status) log_mismatch("status", got.status, want.status);
      if (got.hit !== want.hit) log_mismatch("hit", got.hit, want.hit);
      if (got.fetch_needed !== want.fetch_needed)
         log_mismatch("fetch_needed", got.fetch_needed, want.fetch_needed);
      if (got.writeback_needed !== want.writeback_needed)
         log_mismatch("writeback_needed", got.writeback_needed, want.writeback_needed);
      if (got.resident_count !== want.resident_count)
         log_mismatch("resident_count", got.resident_count, want.resident_count);
      if (got.lru_valid !== want.lru_valid) log_mismatch("lru_valid", got.lru_valid, want.lru_valid);
      if (got.lru_block !== want.lru_block) log_mismatch("lru_block", got.lru_block, want.lru_block);
   endtask

   // Observe every transfer at the clock edge; predict on accept, check on strobe.
   always @(posedge clock) begin : monitor
      dir_result_t got, want;
      logic active;
      int i, stall_cycles;
      if (reset) begin
         for (i = 0; i < ENTRIES; i++) begin
            dir_tag[i] = '0;
            dir_valid[i] = 1'b0;
            dir_dirty[i] = 1'b0;
            dir_age[i] = 0;
         end
         dir_used = 0;
         dir_limit = LIMIT_RESET;
         stall_cycles = 0;
         pending_n <= 0;
      end else begin
         active = 1'b0;
         if (rsp_valid) begin
            active = 1'b1;
            got.status = rsp_status;
            got.hit = rsp_hit;
            got.fetch_needed = rsp_fetch_needed;
            got.writeback_needed = rsp_writeback_needed;
            got.resident_count = rsp_resident_count;
            got.lru_valid = rsp_lru_valid;
            got.lru_block = rsp_lru_block;
            if (expected_q.size() == 0) begin
               log_mismatch("result with nothing pending", got.lru_block, '0);
            end else begin
               want = expected_q.pop_front();
               compare_result(got, want);
            end
            retired_n++;
         end
         if (csr_valid && csr_ready) begin
            active = 1'b1;
            dir_limit = csr_data;
            cfg_n++;
         end
         if (start && !busy) begin
            active = 1'b1;
            want = apply_access(req_mode, req_block_id);
            hit_n += want.hit;
            fetch_n += want.fetch_needed;
            wb_n += want.writeback_needed;
            if (want.status == STATUS_FULL) full_n++;
            if (want.status == STATUS_NOT_RESIDENT) absent_n++;
            if (req_typed) want = req_typed_res;
            expected_q = {expected_q, want};
            items_n++;
         end
         pending_n <= expected_q.size();
         if (active) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_lru_block_cache_directory failed");
            $finish;
         end
      end
   end

   task automatic send_item(logic [MODE_W-1:0] mode, logic [ID_IN_W-1:0] id,
                            logic typed, dir_result_t res);
      req_mode <= mode;
      req_block_id <= id;
      req_typed <= typed;
      req_typed_res <= res;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Hold start through a burst; between bursts, usually drop it for a random gap.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 45);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 30);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_n != 0 || busy) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_row(stim_row_t row);
      directed_q = {directed_q, row};
   endtask

   function automatic stim_row_t access_row(logic [MODE_W-1:0] mode, logic [ID_IN_W-1:0] id);
      stim_row_t row;
      row = '0;
      row.mode = mode;
      row.block_id = id;
      return row;
   endfunction

   function automatic stim_row_t typed_row(logic [MODE_W-1:0] mode, logic [ID_IN_W-1:0] id,
                                           logic [STATUS_W-1:0] status, logic hit, logic fetch,
                                           logic wb, logic [COUNT_OUT_W-1:0] count,
                                           logic lru_valid, logic [ID_IN_W-1:0] lru_block);
      stim_row_t row;
      row = access_row(mode, id);
      row.typed = 1'b1;
      row.res.status = status;
      row.res.hit = hit;
      row.res.fetch_needed = fetch;
      row.res.writeback_needed = wb;
      row.res.resident_count = count;
      row.res.lru_valid = lru_valid;
      row.res.lru_block = lru_block;
      return row;
   endfunction

   function automatic stim_row_t limit_row(logic [LIMIT_W-1:0] value);
      stim_row_t row;
      row = '0;
      row.is_cfg = 1'b1;
      row.limit = value;
      return row;
   endfunction

   initial begin : stimulus
      stim_row_t row;
      logic [MODE_W-1:0] mode;
      logic [ID_IN_W-1:0] id;
      int p, n, i, pool_n;
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_READ;
      req_block_id <= '0;
      req_typed <= 1'b0;
      req_typed_res <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      mismatch_n = 0;
      items_n = 0;
      retired_n = 0;
      cfg_n = 0;
      hit_n = 0;
      fetch_n = 0;
      full_n = 0;
      absent_n = 0;
      wb_n = 0;
      burst_left = 0;

      // empty directory, id extremes, every mode, dirty and clean drops
      queue_row(typed_row(MODE_DROP, 32'd5, STATUS_NOT_RESIDENT,
                          1'b0, 1'b0, 1'b0, 5'd0, 1'b0, 32'd0));
      queue_row(typed_row(MODE_READ, 32'd0, STATUS_OK,
                          1'b0, 1'b1, 1'b0, 5'd1, 1'b1, 32'd0));
      queue_row(typed_row(MODE_WRITE, 32'hFFFF_FFFF, STATUS_OK,
                          1'b0, 1'b1, 1'b0, 5'd2, 1'b1, 32'd0));
      queue_row(access_row(MODE_READ, 32'd0));
      queue_row(access_row(MODE_LOCK, 32'hFFFF_FFFF));
      queue_row(access_row(MODE_WRITE, 32'd0));
      queue_row(access_row(MODE_DROP, 32'd0));
      queue_row(typed_row(MODE_DROP, 32'hFFFF_FFFF, STATUS_OK,
                          1'b1, 1'b0, 1'b1, 5'd0, 1'b0, 32'd0));
      queue_row(typed_row(MODE_DROP, 32'hFFFF_FFFF, STATUS_NOT_RESIDENT,
                          1'b0, 1'b0, 1'b0, 5'd0, 1'b0, 32'd0));
      queue_row(typed_row(MODE_LOCK, 32'hA5A5_A5A5, STATUS_OK,
                          1'b0, 1'b1, 1'b0, 5'd1, 1'b1, 32'hA5A5_A5A5));
      queue_row(access_row(MODE_READ, 32'h5A5A_5A5A));
      queue_row(access_row(MODE_LOCK, 32'hA5A5_A5A5));
      queue_row(access_row(MODE_DROP, 32'hA5A5_A5A5));
      // zero limit: every miss is refused
      queue_row(limit_row(5'd0));
      queue_row(access_row(MODE_READ, 32'd7));
      // limit above the entry count saturates
      queue_row(limit_row(5'd31));
      queue_row(access_row(MODE_READ, 32'd7));
      queue_row(access_row(MODE_WRITE, 32'h8000_0001));
      // limit lowered below the resident count, then drained by drops
      queue_row(limit_row(5'd1));
      queue_row(access_row(MODE_READ, 32'd9));
      queue_row(access_row(MODE_DROP, 32'd7));
      queue_row(access_row(MODE_DROP, 32'h5A5A_5A5A));
      queue_row(access_row(MODE_READ, 32'd9));
      queue_row(access_row(MODE_DROP, 32'h8000_0001));
      queue_row(access_row(MODE_READ, 32'd9));
      queue_row(access_row(MODE_READ, 32'd10));
      queue_row(limit_row(5'd16));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_q[i]) begin
         row = directed_q[i];
         if (row.is_cfg) begin
            wait_idle();
            write_limit(row.limit);
         end else begin
            send_item(row.mode, row.block_id, row.typed, row.res);
            pace();
         end
      end

      // each phase drains the directory pipeline, sets a new limit, then works a small id pool
      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         write_limit((p == 7) ? LIMIT_W'($urandom_range(31)) : LIMIT_W'(limit_plan[p]));
         pool_n = $urandom_range(2, MAX_POOL);
         for (i = 0; i < pool_n; i++) id_pool[i] = $urandom;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            mode = MODE_W'($urandom_range(3));
            if ($urandom_range(99) < 8) id = $urandom;
            else id = id_pool[$urandom_range(pool_n - 1)];
            send_item(mode, id, 1'b0, '0);
            pace();
         end
      end

      wait_idle();
      repeat (LATENCY + 8) @(posedge clock);
      if (expected_q.size() != 0) log_mismatch("results never arrived", expected_q.size(), 0);
      $display("covered %0d accesses over %0d limit settings: %0d hits, %0d fetches",
               items_n, cfg_n, hit_n, fetch_n);
      $display("refused as full %0d, drops of absent blocks %0d, writebacks %0d, mismatches %0d",
               full_n, absent_n, wb_n, mismatch_n);
      if (mismatch_n == 0) begin
         $display("tb_lru_block_cache_directory passed");
      end else begin
         $display("tb_lru_block_cache_directory failed");
      end
      $finish;
   end

endmodule
